// ===== rtl/core/window_std_activity_classifier_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef WINDOW_STD_ACTIVITY_CLASSIFIER_CORE_MACROS_SVH
`define WINDOW_STD_ACTIVITY_CLASSIFIER_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define WSAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define WSAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/wsac_pkg.sv =====
// ----------------------------------------------------------------------------
// wsac_pkg
// Types and constants shared by the activity classifier core.
// ----------------------------------------------------------------------------
package wsac_pkg;

	localparam logic [1:0] MODE_PUSH     = 2'd0;
	localparam logic [1:0] MODE_CLASSIFY = 2'd1;
	localparam logic [1:0] MODE_RESTART  = 2'd2;

	localparam logic [1:0] CLASS_OTHER   = 2'd0;
	localparam logic [1:0] CLASS_WALKING = 2'd1;
	localparam logic [1:0] CLASS_RUNNING = 2'd2;

	localparam logic [1:0] REG_RUN_THR  = 2'd0;
	localparam logic [1:0] REG_WALK_THR = 2'd1;
	localparam logic [1:0] REG_CONFIRM  = 2'd2;

	localparam logic [7:0] STREAK_MAX = 8'd255;
	localparam int CFG_W = 16;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} in_word_t;

	typedef struct packed {
		logic [1:0] activity;
		logic       window_full;
	} out_word_t;

endpackage

// ===== rtl/core/window_std_activity_classifier_core.sv =====
// ----------------------------------------------------------------------------
// window_std_activity_classifier_core
// Sliding-window standard-deviation activity classifier.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_ready) carry a mode and a Q8.8 acceleration:
// push a sample, classify, or restart the window. Each accepted word yields
// exactly one output word (out_valid/out_ready) with the committed class and
// the window-full flag. Registers are written through cfg_we/cfg_idx/cfg_data,
// by the user only while the core is idle; the core does not enforce this.
// The front squares the three axes in turn on one multiplier and then offers
// the sum. The back takes a push through a 16-step square root, a ring read
// and the sum update, a classify of a full window through the shared 16x16
// multiplier and straight to the class update otherwise; a restart goes
// straight to the output word. The back takes no new word until its output
// word is taken. One word is in the back at a time, a second in the front.
// Reset clears sums, fill, position, class state and thresholds to defaults;
// ring contents are not cleared. A stalled receiver holds the output word
// and backs up both stages.
// ----------------------------------------------------------------------------
module window_std_activity_classifier_core #(
	parameter int WINDOW_LEN = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wsac_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output wsac_pkg::out_word_t out_word,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_idx,
	input  logic [15:0]         cfg_data
);
	logic [15:0] run_thr_q, walk_thr_q;
	logic [7:0]  confirm_q;
	logic        q_valid, q_ready;
	logic [1:0]  q_mode;
	logic [31:0] q_sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_thr_q <= 16'd1536;
			walk_thr_q <= 16'd384;
			confirm_q <= 8'd3;
		end else if (cfg_we) begin
			case (cfg_idx)
				wsac_pkg::REG_RUN_THR:  run_thr_q <= cfg_data;
				wsac_pkg::REG_WALK_THR: walk_thr_q <= cfg_data;
				wsac_pkg::REG_CONFIRM:  confirm_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	wsac_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_word,
		.q_valid, .q_ready, .q_mode, .q_sq
	);

	wsac_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_mode, .q_sq,
		.run_thr(run_thr_q), .walk_thr(walk_thr_q), .confirm(confirm_q),
		.out_valid, .out_ready, .out_word
	);
endmodule

// ===== rtl/core/wsac_ram.sv =====
// ----------------------------------------------------------------------------
// wsac_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module wsac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/core/wsac_front.sv =====
// ----------------------------------------------------------------------------
// wsac_front
// Input stage: accepts words and computes the squared magnitude.
// ----------------------------------------------------------------------------
module wsac_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wsac_pkg::in_word_t  in_word,
	output logic                q_valid,
	input  logic                q_ready,
	output logic [1:0]          q_mode,
	output logic [31:0]         q_sq
);
	logic [2:0]  st_q;
	logic [1:0]  mode_q;
	logic [31:0] sq_q;
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [15:0] opnd;
	logic signed [31:0] prod;

	localparam logic [2:0] F_IDLE = 3'd0, F_X = 3'd1, F_Y = 3'd2, F_Z = 3'd3, F_OUT = 3'd4;

	assign in_ready = (st_q == F_IDLE);
	assign q_valid  = (st_q == F_OUT);
	assign q_mode   = mode_q;
	assign q_sq     = sq_q;

	always_comb begin
		case (st_q)
			F_X:     opnd = ax_q;
			F_Y:     opnd = ay_q;
			default: opnd = az_q;
		endcase
		prod = opnd * opnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			case (st_q)
				F_IDLE: if (in_valid) st_q <= F_X;
				F_X:    st_q <= F_Y;
				F_Y:    st_q <= F_Z;
				F_Z:    st_q <= F_OUT;
				F_OUT:  if (q_ready) st_q <= F_IDLE;
				default: st_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			F_IDLE: begin
				mode_q <= in_word.mode;
				ax_q <= in_word.accel_x;
				ay_q <= in_word.accel_y;
				az_q <= in_word.accel_z;
			end
			F_X: sq_q <= $unsigned(prod);
			F_Y, F_Z: sq_q <= sq_q + $unsigned(prod);
			default: ;
		endcase
	end
endmodule

// ===== rtl/core/wsac_back.sv =====
// ----------------------------------------------------------------------------
// wsac_back
// Execution: square root, window ring, running sums, threshold test, output.
// ----------------------------------------------------------------------------
module wsac_back #(
	parameter int WINDOW_LEN = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_ready,
	input  logic [1:0]          q_mode,
	input  logic [31:0]         q_sq,
	input  logic [15:0]         run_thr,
	input  logic [15:0]         walk_thr,
	input  logic [7:0]          confirm,
	output logic                out_valid,
	input  logic                out_ready,
	output wsac_pkg::out_word_t out_word
);
	localparam int AW  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CW  = $clog2(WINDOW_LEN + 1);
	localparam int S1W = 16 + CW;
	localparam int S2W = 32 + CW;
	localparam int BW  = S2W + CW + 2;
	localparam logic [CW-1:0] NFULL = CW'(WINDOW_LEN);

	localparam logic [3:0] B_IDLE = 4'd0, B_SQRT = 4'd1, B_RD = 4'd2, B_SUB = 4'd3,
		B_ADD = 4'd4, B_M1 = 4'd5, B_M2 = 4'd6, B_M3 = 4'd7, B_M4 = 4'd8,
		B_CMP = 4'd9, B_CLS = 4'd10, B_OUT = 4'd11;

	logic [3:0]  st_q;
	logic [1:0]  mode_q;
	logic [31:0] rem_q;
	logic [15:0] root_q;
	logic [4:0]  it_q;
	logic [AW-1:0] wpos_q;
	logic [CW-1:0] fill_q;
	logic [S1W-1:0] s1_q;
	logic [S2W-1:0] s2_q;
	logic [1:0]  prev_q, comm_q;
	logic [7:0]  streak_q;
	logic        pass_q;
	logic [15:0] ma_q, mb_q;
	logic [31:0] mp_q;
	logic [BW-1:0] acc_q, spread_q;
	logic [1:0]  part_q;
	logic [15:0] rdata;
	logic        ram_we;
	logic        full;

	// 16x16 shared multiplier, registered
	always_ff @(posedge clk) mp_q <= ma_q * mb_q;

	assign full = (fill_q == NFULL);
	assign ram_we = (st_q == B_ADD) && (mode_q == wsac_pkg::MODE_PUSH);
	assign q_ready = (st_q == B_IDLE);
	assign out_valid = (st_q == B_OUT);
	assign out_word.activity = comm_q;
	assign out_word.window_full = full;

	wsac_ram #(.WIDTH(16), .DEPTH(WINDOW_LEN)) u_ram (
		.clk(clk), .we(ram_we), .addr(wpos_q), .wdata(root_q), .rdata(rdata)
	);

	// sqrt trial
	logic [17:0] trial;
	assign trial = {root_q, 2'b01};

	logic [31:0] sqv_q;
	logic [15:0] rh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			wpos_q <= '0;
			fill_q <= '0;
			s1_q <= '0;
			s2_q <= '0;
			prev_q <= wsac_pkg::CLASS_OTHER;
			comm_q <= wsac_pkg::CLASS_OTHER;
			streak_q <= '0;
		end else begin
			case (st_q)
				B_IDLE: if (q_valid) begin
					mode_q <= q_mode;
					sqv_q <= q_sq;
					rem_q <= '0;
					root_q <= '0;
					it_q <= 5'd0;
					part_q <= 2'd0;
					case (q_mode)
						wsac_pkg::MODE_PUSH: st_q <= B_SQRT;
						wsac_pkg::MODE_CLASSIFY: st_q <= full ? B_M1 : B_CLS;
						wsac_pkg::MODE_RESTART: begin
							wpos_q <= '0; fill_q <= '0; s1_q <= '0; s2_q <= '0;
							st_q <= B_OUT;
						end
						default: st_q <= B_OUT;
					endcase
					pass_q <= 1'b0;
				end
				B_SQRT: begin
					// restoring sqrt, two radicand bits per step
					if ({16'd0, rem_q[31:0], sqv_q[31:30]} >= {32'd0, trial}) begin
						rem_q <= 32'({rem_q[29:0], sqv_q[31:30]} - {14'd0, trial});
						root_q <= {root_q[14:0], 1'b1};
					end else begin
						rem_q <= {rem_q[29:0], sqv_q[31:30]};
						root_q <= {root_q[14:0], 1'b0};
					end
					sqv_q <= {sqv_q[29:0], 2'b00};
					it_q <= it_q + 5'd1;
					if (it_q == 5'd15) st_q <= B_RD;
				end
				B_RD: begin
					ma_q <= root_q; mb_q <= root_q;
					st_q <= B_SUB;
				end
				B_SUB: begin
					// ram data valid; keep the oldest sample for eviction if full
					ma_q <= rdata; mb_q <= rdata;
					rh_q <= rdata;
					st_q <= B_ADD;
				end
				B_ADD: begin
					// mp_q = root^2 here
					s1_q <= s1_q + S1W'(root_q);
					s2_q <= s2_q + S2W'(mp_q);
					st_q <= B_M4;
				end
				B_M4: begin
					// mp_q = old^2
					if (full) begin
						s1_q <= s1_q - S1W'(rh_q);
						s2_q <= s2_q - S2W'(mp_q);
					end else begin
						fill_q <= fill_q + CW'(1);
					end
					wpos_q <= (wpos_q == AW'(WINDOW_LEN - 1)) ? '0 : wpos_q + AW'(1);
					st_q <= B_OUT;
				end
				B_M1: begin
					// spread = N*S2 - S1^2 with S1^2 from three 16x16 products
					acc_q <= BW'(s2_q) * BW'(WINDOW_LEN);
					spread_q <= '0;
					ma_q <= 16'(s1_q); mb_q <= 16'(s1_q);
					part_q <= 2'd0;
					st_q <= B_M2;
				end
				B_M2: begin
					case (part_q)
						2'd0: begin ma_q <= 16'(s1_q); mb_q <= 16'(s1_q >> 16); end
						2'd1: begin spread_q <= BW'(mp_q); ma_q <= 16'(s1_q >> 16); end
						2'd2: spread_q <= spread_q + (BW'(mp_q) << 17);
						default: spread_q <= spread_q + (BW'(mp_q) << 32);
					endcase
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) begin
						st_q <= B_M3;
						ma_q <= pass_q ? walk_thr : run_thr;
						mb_q <= pass_q ? walk_thr : run_thr;
					end
				end
				B_M3: begin
					spread_q <= (acc_q > spread_q) ? acc_q - spread_q : '0;
					part_q <= 2'd0;
					st_q <= B_CMP;
				end
				B_CMP: begin
					// mp_q = thr^2; N^2*thr^2 fits in BW
					if (part_q == 2'd0) begin
						part_q <= 2'd1;
					end else begin
						if (spread_q > (BW'(mp_q) * BW'(WINDOW_LEN) * BW'(WINDOW_LEN))) begin
							pass_q <= 1'b1;
						end
						part_q <= 2'd0;
						if (spread_q > (BW'(mp_q) * BW'(WINDOW_LEN) * BW'(WINDOW_LEN))) begin
							st_q <= B_CLS;
						end else if (ma_q == run_thr && !pass_q && part_q == 2'd1
							&& it_q == 5'd0) begin
							it_q <= 5'd1;
							ma_q <= walk_thr; mb_q <= walk_thr;
							part_q <= 2'd0;
						end else begin
							st_q <= B_CLS;
						end
					end
				end
				B_CLS: begin
					begin : cls
						logic [1:0] r;
						r = wsac_pkg::CLASS_OTHER;
						if (full && pass_q) r = (it_q == 5'd0) ? wsac_pkg::CLASS_RUNNING
							: wsac_pkg::CLASS_WALKING;
						if (r != prev_q) prev_q <= r;
						streak_q <= (r == prev_q) ?
							((streak_q == wsac_pkg::STREAK_MAX) ? streak_q : streak_q + 8'd1) : 8'd1;
						if (((r == prev_q) ?
							((streak_q == wsac_pkg::STREAK_MAX) ? streak_q : streak_q + 8'd1) : 8'd1)
							>= confirm) comm_q <= r;
					end
					st_q <= B_OUT;
				end
				B_OUT: if (out_ready) st_q <= B_IDLE;
				default: st_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/wsac_checker.sv =====
// ----------------------------------------------------------------------------
// wsac_checker
// Port-level checks for the classifier core.
// ----------------------------------------------------------------------------
`include "window_std_activity_classifier_core_macros.svh"
module wsac_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input wsac_pkg::out_word_t out_word
);
	`WSAC_ASSERT_IMP(a_cls, clk, arst_n, out_valid, out_word.activity != 2'd3, "bad class")
	`WSAC_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid, "valid dropped")
	`WSAC_ASSERT_NXT(a_stable, clk, arst_n, out_valid && !out_ready, $stable(out_word), "word moved")
endmodule

bind window_std_activity_classifier_core wsac_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_ready(out_ready),
	.out_word(out_word)
);
